// ----- sv/sedg_pkg.sv -----
// Shared types and constants for the switch edge debounce gate.
// No dependencies; every other file takes names from here by scope.
`default_nettype none

package sedg_pkg;

   localparam int SW_WIDTH        = 24;
   localparam int TIME_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 24;

   localparam logic [TIME_WIDTH-1:0] SHORT_LOCKOUT_RESET = 16'd10;
   localparam logic [TIME_WIDTH-1:0] LONG_LOCKOUT_RESET  = 16'd25;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ATTRACT_ENABLE = 3'd0,
      CSR_TILT_ENABLE    = 3'd1,
      CSR_LONG_SELECT    = 3'd2,
      CSR_SHORT_LOCKOUT  = 3'd3,
      CSR_LONG_LOCKOUT   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                  take;
      logic [TIME_WIDTH-1:0] now_time;
      logic                  tilt_active;
      logic                  game_running;
      logic [TIME_WIDTH-1:0] short_lockout;
      logic [TIME_WIDTH-1:0] long_lockout;
   } shared_type;

   typedef struct packed {
      logic accept;
      logic fire;
   } lane_type;

   typedef struct packed {
      logic [SW_WIDTH-1:0] fired_mask;
      logic [SW_WIDTH-1:0] accepted_mask;
   } result_type;

endpackage

`default_nettype wire

// ----- sv/sedg_if.sv -----
// Valid/ready channel interfaces for scan requests and gate responses.
// Depends on sedg_pkg for field widths.
`default_nettype none

interface sedg_req_if;
   logic                            valid;
   logic                            ready;
   logic [sedg_pkg::SW_WIDTH-1:0]   raw_switches;
   logic [sedg_pkg::TIME_WIDTH-1:0] now_time;
   logic                            tilt_active;
   logic                            game_running;

   modport source (output valid, raw_switches, now_time, tilt_active, game_running,
                   input ready);
   modport sink   (input valid, raw_switches, now_time, tilt_active, game_running,
                   output ready);
endinterface

interface sedg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sedg_pkg::SW_WIDTH-1:0] fired_mask;
   logic [sedg_pkg::SW_WIDTH-1:0] accepted_mask;

   modport source (output valid, fired_mask, accepted_mask, input ready);
   modport sink   (input valid, fired_mask, accepted_mask, output ready);
endinterface

`default_nettype wire

// ----- sv/switch_edge_debounce_gate_core.sv -----
// A response enters the output queue when its scan transaction is accepted and is presented after earlier ones.
// Throughput: one scan per cycle while the output queue is not full; every switch lane works in parallel, and a
// two-entry output queue keeps req_if.ready high while one response waits.
// Reset (synchronous, active high) clears the previous scan, every timestamp,
// the output queue and the control registers (lockouts return to 10 and 25).
// Depends on sedg_pkg, sedg_if, sedg_lane and sedg_merge.
`default_nettype none

module switch_edge_debounce_gate_core #(
   parameter int NUM_SWITCHES = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   sedg_req_if.sink                                   req_if,
   sedg_rsp_if.source                                 rsp_if,
   input  wire logic                                  csr_we,
   input  wire logic [sedg_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [sedg_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int LANES = (NUM_SWITCHES < sedg_pkg::SW_WIDTH) ?
                          NUM_SWITCHES : sedg_pkg::SW_WIDTH;
   localparam logic [sedg_pkg::SW_WIDTH-1:0] ACTIVE_MASK =
      sedg_pkg::SW_WIDTH'((64'd1 << LANES) - 64'd1);

   logic [sedg_pkg::SW_WIDTH-1:0]   attract_ff;
   logic [sedg_pkg::SW_WIDTH-1:0]   tilt_ff;
   logic [sedg_pkg::SW_WIDTH-1:0]   long_select_ff;
   logic [sedg_pkg::TIME_WIDTH-1:0] short_lockout_ff;
   logic [sedg_pkg::TIME_WIDTH-1:0] long_lockout_ff;
   logic [sedg_pkg::SW_WIDTH-1:0]   prev_scan_ff;
   logic [sedg_pkg::SW_WIDTH-1:0]   prev_scan_in;
   logic                            take;
   logic                            merge_ready;
   sedg_pkg::shared_type            shared;
   sedg_pkg::lane_type              lanes [sedg_pkg::SW_WIDTH];

   assign req_if.ready = merge_ready;
   assign take         = req_if.valid && merge_ready;
   assign prev_scan_in = req_if.raw_switches & ACTIVE_MASK;

   assign shared.take          = take;
   assign shared.now_time      = req_if.now_time;
   assign shared.tilt_active   = req_if.tilt_active;
   assign shared.game_running  = req_if.game_running;
   assign shared.short_lockout = short_lockout_ff;
   assign shared.long_lockout  = long_lockout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attract_ff       <= '0;
         tilt_ff          <= '0;
         long_select_ff   <= '0;
         short_lockout_ff <= sedg_pkg::SHORT_LOCKOUT_RESET;
         long_lockout_ff  <= sedg_pkg::LONG_LOCKOUT_RESET;
      end else if (csr_we) begin
         unique case (sedg_pkg::csr_index_type'(csr_index))
            sedg_pkg::CSR_ATTRACT_ENABLE: attract_ff     <= csr_wdata;
            sedg_pkg::CSR_TILT_ENABLE:    tilt_ff        <= csr_wdata;
            sedg_pkg::CSR_LONG_SELECT:    long_select_ff <= csr_wdata;
            sedg_pkg::CSR_SHORT_LOCKOUT: begin
               short_lockout_ff <= csr_wdata[sedg_pkg::TIME_WIDTH-1:0];
            end
            sedg_pkg::CSR_LONG_LOCKOUT: begin
               long_lockout_ff <= csr_wdata[sedg_pkg::TIME_WIDTH-1:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_scan_ff <= '0;
      end else if (take) begin
         prev_scan_ff <= prev_scan_in;
      end
   end

   for (genvar i = 0; i < sedg_pkg::SW_WIDTH; i++) begin : g_lane
      if (i < LANES) begin : g_active
         sedg_lane u_lane (
            .clock          (clock),
            .reset          (reset),
            .shared         (shared),
            .raw_bit        (req_if.raw_switches[i]),
            .prev_bit       (prev_scan_ff[i]),
            .long_select    (long_select_ff[i]),
            .tilt_enable    (tilt_ff[i]),
            .attract_enable (attract_ff[i]),
            .lane           (lanes[i])
         );
      end else begin : g_unused
         assign lanes[i] = '0;
      end
   end

   sedg_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .push   (take),
      .lanes  (lanes),
      .ready  (merge_ready),
      .rsp_if (rsp_if)
   );

endmodule

`default_nettype wire

// ----- sv/sedg_lane.sv -----
// One switch lane: edge detect, lockout compare, timestamp and mode gating.
// Depends on sedg_pkg for the shared control and lane result structs.
`default_nettype none

module sedg_lane (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sedg_pkg::shared_type shared,
   input  wire logic                 raw_bit,
   input  wire logic                 prev_bit,
   input  wire logic                 long_select,
   input  wire logic                 tilt_enable,
   input  wire logic                 attract_enable,
   output      sedg_pkg::lane_type   lane
);

   logic [sedg_pkg::TIME_WIDTH-1:0] stamp_ff;
   logic [sedg_pkg::TIME_WIDTH-1:0] stamp_in;
   logic [sedg_pkg::TIME_WIDTH-1:0] lockout;
   logic [sedg_pkg::TIME_WIDTH-1:0] elapsed;
   logic                            edge_seen;
   logic                            accept;

   assign lockout   = long_select ? shared.long_lockout : shared.short_lockout;
   assign elapsed   = shared.now_time - stamp_ff;
   assign edge_seen = raw_bit & ~prev_bit;
   assign accept    = edge_seen && (elapsed > lockout);

   assign lane.accept = accept;
   assign lane.fire   = accept && (!shared.tilt_active || tilt_enable)
                               && (shared.game_running || attract_enable);

   assign stamp_in = (shared.take && accept) ? shared.now_time : stamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff <= '0;
      end else begin
         stamp_ff <= stamp_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/sedg_merge.sv -----
// Merge of lane results into response masks, held in a two-entry output queue.
// Depends on sedg_pkg and the sedg_rsp_if channel interface.
`default_nettype none

module sedg_merge (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire sedg_pkg::lane_type lanes [sedg_pkg::SW_WIDTH],
   output      logic               ready,
   sedg_rsp_if.source              rsp_if
);

   sedg_pkg::result_type entry_ff [2];
   sedg_pkg::result_type merged;
   logic [1:0]           count_ff;
   logic [1:0]           count_in;
   logic                 wr_ptr_ff;
   logic                 rd_ptr_ff;
   logic                 pop;

   always_comb begin
      for (int i = 0; i < sedg_pkg::SW_WIDTH; i++) begin
         merged.fired_mask[i]    = lanes[i].fire;
         merged.accepted_mask[i] = lanes[i].accept;
      end
   end

   assign ready                = (count_ff != 2'd2);
   assign pop                  = rsp_if.valid && rsp_if.ready;
   assign rsp_if.valid         = (count_ff != 2'd0);
   assign rsp_if.fired_mask    = entry_ff[rd_ptr_ff].fired_mask;
   assign rsp_if.accepted_mask = entry_ff[rd_ptr_ff].accepted_mask;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= merged;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

endmodule

`default_nettype wire

// ----- sv/sedg_checker.sv -----
// Port-level checks for switch_edge_debounce_gate_core, bound to the top level.
// Depends on sedg_pkg for mask widths.
`default_nettype none

module sedg_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [sedg_pkg::SW_WIDTH-1:0] fired_mask,
   input wire logic [sedg_pkg::SW_WIDTH-1:0] accepted_mask
);

   a_fired_within_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((fired_mask & ~accepted_mask) == '0))
      else $error("fired switch not in accepted mask");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no response pending");

   a_response_follows_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted transaction produced no response");

   a_response_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(fired_mask) && $stable(accepted_mask)))
      else $error("stalled response changed");

endmodule

bind switch_edge_debounce_gate_core sedg_checker u_sedg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .fired_mask    (rsp_if.fired_mask),
   .accepted_mask (rsp_if.accepted_mask)
);

`default_nettype wire
